// ===== rtl/smtp_body_crlf_dot_stuffer_defines.svh =====
// Assertion macros used by the top-level RTL.
`ifndef SMTP_BODY_CRLF_DOT_STUFFER_DEFINES_SVH
`define SMTP_BODY_CRLF_DOT_STUFFER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SBCDS_ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SBCDS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sbcds_pkg.sv =====
`timescale 1ns / 1ps

package sbcds_pkg;

    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;

    // Output byte slots of one word, emitted lowest first.
    localparam int NUM_SLOTS = 7;
    localparam logic [2:0] SLOT_PRE_DOT  = 3'd0;
    localparam logic [2:0] SLOT_BODY     = 3'd1;
    localparam logic [2:0] SLOT_CR       = 3'd2;
    localparam logic [2:0] SLOT_LF       = 3'd3;
    localparam logic [2:0] SLOT_TERM_DOT = 3'd4;
    localparam logic [2:0] SLOT_TERM_CR  = 3'd5;
    localparam logic [2:0] SLOT_TERM_LF  = 3'd6;

    typedef logic [NUM_SLOTS-1:0] slot_mask_t;

    // Classified word handed from the front to the back.
    typedef struct packed {
        logic [7:0] data;
        slot_mask_t slots;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic logic [7:0] slot_byte(input logic [2:0] slot, input logic [7:0] data);
        logic [7:0] b;
        unique case (slot) inside
            SLOT_PRE_DOT, SLOT_TERM_DOT: b = CH_DOT;
            SLOT_CR, SLOT_TERM_CR:       b = CH_CR;
            SLOT_LF, SLOT_TERM_LF:       b = CH_LF;
            SLOT_BODY:                   b = data;
            default:                     b = data;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/sbcds_queue.sv =====
`timescale 1ns / 1ps

module sbcds_queue #(
    parameter int DEPTH = 4
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  sbcds_pkg::cmd_t         push_cmd,
    input  logic                    pop,
    output sbcds_pkg::cmd_t         head_cmd,
    output sbcds_pkg::queue_status_t status
);
    import sbcds_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head_cmd     = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

// ===== rtl/sbcds_front.sv =====
`timescale 1ns / 1ps

module sbcds_front (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [7:0]               s_axis_tdata,
    input  logic [0:0]               s_axis_tuser,
    input  logic                     s_axis_tlast,
    input  sbcds_pkg::queue_status_t q_status,
    output logic                     push,
    output sbcds_pkg::cmd_t          push_cmd
);
    import sbcds_pkg::*;

    logic       after_cr_reg, after_cr_next;
    logic       line_start_reg, line_start_next;
    logic       ends_crlf_reg, ends_crlf_next;
    logic       accept;
    logic       is_cr, is_lf;
    slot_mask_t slots;

    assign is_cr = (s_axis_tdata == CH_CR);
    assign is_lf = (s_axis_tdata == CH_LF);

    always_comb begin
        after_cr_next   = after_cr_reg;
        line_start_next = line_start_reg;
        ends_crlf_next  = ends_crlf_reg;
        slots           = '0;
        if (s_axis_tuser[0]) begin
            if (is_lf && after_cr_reg) begin
                // drop LF of a CR LF pair
                after_cr_next = 1'b0;
            end else if (is_cr || is_lf) begin
                slots[SLOT_CR]  = 1'b1;
                slots[SLOT_LF]  = 1'b1;
                after_cr_next   = is_cr;
                line_start_next = 1'b1;
                ends_crlf_next  = 1'b1;
            end else begin
                slots[SLOT_BODY]    = 1'b1;
                slots[SLOT_PRE_DOT] = line_start_reg && (s_axis_tdata == CH_DOT);
                after_cr_next       = 1'b0;
                line_start_next     = 1'b0;
                ends_crlf_next      = 1'b0;
            end
        end
        if (s_axis_tlast) begin
            if (!ends_crlf_next) begin
                slots[SLOT_CR] = 1'b1;
                slots[SLOT_LF] = 1'b1;
            end
            slots[SLOT_TERM_DOT] = 1'b1;
            slots[SLOT_TERM_CR]  = 1'b1;
            slots[SLOT_TERM_LF]  = 1'b1;
            after_cr_next        = 1'b0;
            line_start_next      = 1'b1;
            ends_crlf_next       = 1'b0;
        end
    end

    assign s_axis_tready  = !q_status.full;
    assign accept         = s_axis_tvalid && s_axis_tready;
    assign push           = accept && (slots != '0);
    assign push_cmd.data  = s_axis_tdata;
    assign push_cmd.slots = slots;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            after_cr_reg   <= 1'b0;
            line_start_reg <= 1'b1;
            ends_crlf_reg  <= 1'b0;
        end else if (accept) begin
            after_cr_reg   <= after_cr_next;
            line_start_reg <= line_start_next;
            ends_crlf_reg  <= ends_crlf_next;
        end
    end

endmodule

// ===== rtl/sbcds_back.sv =====
`timescale 1ns / 1ps

module sbcds_back (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  sbcds_pkg::cmd_t          head_cmd,
    input  sbcds_pkg::queue_status_t q_status,
    output logic                     pop,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [7:0]               m_axis_tdata,
    output logic                     m_axis_tlast
);
    import sbcds_pkg::*;

    slot_mask_t done_reg;
    slot_mask_t cur, low, rest;
    logic       valid_reg;
    logic [7:0] data_reg, data_next;
    logic       last_reg;
    logic       load;

    // pick the lowest slot still pending in the head word
    assign cur  = head_cmd.slots & ~done_reg;
    assign low  = cur & (~cur + slot_mask_t'(1));
    assign rest = cur & ~low;

    always_comb begin
        data_next = head_cmd.data;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (low[i]) begin
                data_next = slot_byte(3'(i), head_cmd.data);
            end
        end
    end

    assign load = !q_status.empty && (!valid_reg || m_axis_tready);
    assign pop  = load && (rest == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            done_reg  <= '0;
        end else if (load) begin
            valid_reg <= 1'b1;
            done_reg  <= (rest == '0) ? '0 : (done_reg | low);
        end else if (m_axis_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_next;
            last_reg <= (rest == '0);
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;
    assign m_axis_tlast  = last_reg;

endmodule

// ===== rtl/smtp_body_crlf_dot_stuffer.sv =====
`timescale 1ns / 1ps

// SMTP DATA payload builder: takes one body byte per input word (tuser[0] marks a
// real byte, tlast ends the body) and emits the payload with line breaks normalized
// to CR LF, dots at line start doubled and the CR LF . CR LF terminator appended;
// tlast on the output marks the final byte caused by each input word. Input words
// are taken one per cycle while the command queue (QUEUE_DEPTH entries) has room;
// the output sequencer sends one byte per cycle while the receiver is ready, so a word
// that expands to several bytes (at most 7) holds the output side until all are sent,
// and the queue absorbs the difference. A word is queued, then registered for output.
module smtp_body_crlf_dot_stuffer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0] s_axis_tuser,   // [0] byte_valid
    input  logic       s_axis_tlast,   // end_of_body
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast    // last_of_run
);
    import sbcds_pkg::*;

    logic          push, pop;
    cmd_t          push_cmd, head_cmd;
    queue_status_t q_status;

    sbcds_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .q_status      (q_status),
        .push          (push),
        .push_cmd      (push_cmd)
    );

    sbcds_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (q_status)
    );

    sbcds_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_cmd      (head_cmd),
        .q_status      (q_status),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

`include "smtp_body_crlf_dot_stuffer_defines.svh"

    `SBCDS_ASSERT_IMPLIES(a_push_not_empty, aclk, aresetn, push, push_cmd.slots != '0, "empty word queued")
    `SBCDS_ASSERT_IMPLIES(a_pre_dot_body, aclk, aresetn, push && push_cmd.slots[SLOT_PRE_DOT], push_cmd.slots[SLOT_BODY] && (push_cmd.data == CH_DOT), "stuffed dot without body dot")
    `SBCDS_ASSERT_IMPLIES(a_term_whole, aclk, aresetn, push, (push_cmd.slots[SLOT_TERM_DOT] == push_cmd.slots[SLOT_TERM_CR]) && (push_cmd.slots[SLOT_TERM_CR] == push_cmd.slots[SLOT_TERM_LF]), "partial terminator")
    `SBCDS_ASSERT_NEXT(a_pop_marks_last, aclk, aresetn, pop, m_axis_tvalid && m_axis_tlast, "word retired without tlast")

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import sbcds_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int RANDOM_WORDS = 150;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } payload_byte_t;

    // Tracks line state of the body and the payload bytes still owed by the block.
    class payload_scoreboard;
        payload_byte_t expected_payload[$];
        bit after_cr;
        bit line_start;
        bit ends_crlf;
        int errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            after_cr = 1'b0;
            line_start = 1'b1;
            ends_crlf = 1'b0;
        endfunction

        function int pending();
            return expected_payload.size();
        endfunction

        // Expand one accepted input word into the payload bytes it causes.
        function void note_word(logic [7:0] b, logic v, logic e);
            payload_byte_t run[$];
            if (v) begin
                if (b == CH_LF && after_cr) begin
                    after_cr = 1'b0;
                end else if (b == CH_CR || b == CH_LF) begin
                    run.push_back(payload_byte_t'{CH_CR, 1'b0});
                    run.push_back(payload_byte_t'{CH_LF, 1'b0});
                    after_cr = (b == CH_CR);
                    line_start = 1'b1;
                    ends_crlf = 1'b1;
                end else begin
                    if (line_start && b == CH_DOT)
                        run.push_back(payload_byte_t'{CH_DOT, 1'b0});
                    run.push_back(payload_byte_t'{b, 1'b0});
                    after_cr = 1'b0;
                    line_start = 1'b0;
                    ends_crlf = 1'b0;
                end
            end
            if (e) begin
                if (!ends_crlf) begin
                    run.push_back(payload_byte_t'{CH_CR, 1'b0});
                    run.push_back(payload_byte_t'{CH_LF, 1'b0});
                end
                run.push_back(payload_byte_t'{CH_DOT, 1'b0});
                run.push_back(payload_byte_t'{CH_CR, 1'b0});
                run.push_back(payload_byte_t'{CH_LF, 1'b0});
                restart();
            end
            if (run.size() != 0)
                run[run.size()-1].last = 1'b1;
            foreach (run[i])
                expected_payload.push_back(run[i]);
        endfunction

        function void check_byte(logic [7:0] d, logic l);
            payload_byte_t exp_byte;
            if (expected_payload.size() == 0) begin
                $display("%0t: unexpected payload byte %02h last %0b", $time, d, l);
                errors++;
                return;
            end
            exp_byte = expected_payload.pop_front();
            if (d !== exp_byte.data) begin
                $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                         $time, exp_byte.data, d);
                errors++;
            end
            if (l !== exp_byte.last) begin
                $display("%0t: last_of_run mismatch: expected %0b, actual %0b",
                         $time, exp_byte.last, l);
                errors++;
            end
        endfunction
    endclass

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;
    logic [0:0] s_axis_tuser = 1'b0;
    logic       s_axis_tlast = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;

    payload_scoreboard sb = new();
    int words_sent = 0;
    int cycle_count = 0;

    smtp_body_crlf_dot_stuffer i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Mostly short stalls, now and then a long one.
    function automatic int stall_len();
        int r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        else if (r < 93)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    // Body bytes biased toward line breaks and dots.
    function automatic logic [7:0] body_byte();
        int r = $urandom_range(0, 99);
        if (r < 15)
            return CH_CR;
        else if (r < 28)
            return CH_LF;
        else if (r < 40)
            return CH_DOT;
        return 8'($urandom_range(0, 255));
    endfunction

    bit sender_steady = 1'b0;
    bit draining = 1'b0;

    task automatic pause_sender(input int n);
        if (n > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic send_word(input logic [7:0] d, input logic v, input logic e);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        s_axis_tuser <= v;
        s_axis_tlast <= e;
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
        sb.note_word(d, v, e);
        if (v || e)
            words_sent++;
        if (!sender_steady && $urandom_range(0, 99) < 30)
            pause_sender(stall_len());
    endtask

    task automatic wait_drained();
        draining = 1'b1;
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0)
            @(posedge aclk);
        draining = 1'b0;
    endtask

    task automatic send_body();
        int len;
        int r;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 30) : $urandom_range(0, 10);
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(0, 99);
            if (r < 8)
                send_word(8'($urandom_range(0, 255)), 1'($urandom), 1'($urandom));
            else if (r < 16)
                send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            else
                send_word(body_byte(), 1'b1, 1'b0);
        end
        // Some bodies end on a bare terminator word, most on a final byte.
        send_word(body_byte(), ($urandom_range(0, 3) != 0), 1'b1);
    endtask

    initial begin : sender
        int steady_left;
        steady_left = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_word(8'h41, 1'b0, 1'b0);       // idle word
        send_word(8'h00, 1'b0, 1'b1);       // empty body
        send_word(CH_DOT, 1'b1, 1'b0);      // dot opening the body
        send_word(8'h00, 1'b1, 1'b0);
        send_word(8'hFF, 1'b1, 1'b0);
        send_word(CH_CR, 1'b1, 1'b0);
        send_word(CH_LF, 1'b1, 1'b0);       // LF after CR: dropped
        send_word(CH_DOT, 1'b1, 1'b0);
        send_word(CH_LF, 1'b1, 1'b0);       // lone LF
        send_word(CH_LF, 1'b1, 1'b0);
        send_word(CH_CR, 1'b1, 1'b0);
        send_word(CH_CR, 1'b1, 1'b0);
        send_word(CH_LF, 1'b1, 1'b1);       // dropped LF with terminator
        send_word(CH_DOT, 1'b1, 1'b1);      // longest expansion
        send_word(CH_CR, 1'b1, 1'b1);
        send_word(8'hA5, 1'b0, 1'b0);
        send_word(8'h5A, 1'b1, 1'b0);
        send_word(CH_CR, 1'b1, 1'b0);
        send_word(CH_LF, 1'b0, 1'b1);       // terminator with CR pending
        send_word(8'h7F, 1'b1, 1'b1);
        send_word(CH_LF, 1'b1, 1'b1);
        wait_drained();

        words_sent = 0;
        while (words_sent < RANDOM_WORDS) begin
            if (steady_left == 0) begin
                sender_steady = ($urandom_range(0, 3) == 0);
                steady_left = $urandom_range(2, 6);
            end
            steady_left--;
            send_body();
            if ($urandom_range(0, 19) == 0)
                wait_drained();
        end
        wait_drained();
        repeat (20) @(posedge aclk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("smtp_body_crlf_dot_stuffer test passed");
        else
            $display("smtp_body_crlf_dot_stuffer test failed");
        $finish;
    end

    initial begin : receiver
        int stall;
        int steady_left;
        int received;
        bit steady;
        bit hold_done;
        stall = 0;
        steady_left = 0;
        received = 0;
        steady = 1'b0;
        hold_done = 1'b0;
        while (!aresetn)
            @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_byte(m_axis_tdata, m_axis_tlast);
                received++;
            end
            if (steady_left == 0) begin
                steady = ($urandom_range(0, 3) == 0);
                steady_left = $urandom_range(20, 80);
            end
            steady_left--;
            if (!hold_done && !draining && received >= 80) begin
                // Hold off long enough for the input side to back up.
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
            end else if (stall > 0) begin
                m_axis_tready <= 1'b0;
                stall--;
            end else if (!steady && $urandom_range(0, 99) < 25) begin
                m_axis_tready <= 1'b0;
                stall = stall_len() - 1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("smtp_body_crlf_dot_stuffer test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/sbcds_pkg.sv
rtl/sbcds_queue.sv
rtl/sbcds_front.sv
rtl/sbcds_back.sv
rtl/smtp_body_crlf_dot_stuffer.sv
dv/tb.sv
